[hw/rtl/ftphc_pkg.sv]
// Shared types and constants of the first-touch page hit counter.
// Holds the payload structs, field widths and register map.
// Depends on nothing; every RTL file of the block imports it.
`default_nettype none

package ftphc_pkg;

  // Field widths of one record beat and one result beat.
  localparam int unsigned PAGE_W   = 52;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned CREDIT_W = 7;
  localparam int unsigned TOTAL_W  = 48;
  localparam int unsigned LIMIT_W  = 7;

  // Access counts are clipped to this value before they are credited.
  localparam logic [CREDIT_W-1:0] CLIP_MAX = 7'd64;

  // Defaults of the top-level parameters.
  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned PAGE_BITS_DEF   = 52;

  // Configuration port and register map.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [LIMIT_W-1:0] FAST_LIMIT_RESET = 7'd64;
  localparam logic [0:0] REG_FAST_LIMIT = 1'b0;

  // One trace record.
  typedef struct packed {
    logic [PAGE_W-1:0]  page_number;
    logic [COUNT_W-1:0] access_count;
  } item_t;

  // One result.
  typedef struct packed {
    logic                is_hit;
    logic                new_page;
    logic [CREDIT_W-1:0] credited;
    logic [TOTAL_W-1:0]  hit_total;
    logic [TOTAL_W-1:0]  miss_total;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/first_touch_page_hit_counter_core.sv]
// First-touch page hit counter: top level with table, search sequencer and totals.
// Depends on ftphc_pkg for the payload structs, widths and register map.
`default_nettype none

// Usage
// A record beat is taken at a rising edge where start is high and busy is low.
// The page is searched for in a table of first-seen pages, one entry a cycle
// through a single comparator and a registered memory read port. If it is not
// found and the table holds fewer pages than fast_limit (clamped to TABLE_DEPTH), it is appended.
// The clipped count then goes through one shared saturating adder into the
// hit total or the miss total.
// The result beat shows on result_o with result_strobe_o high for one
// cycle, once the search has compared the entries up to the match (or all
// pages held) and the decide state has registered it. busy stays high until
// then and falls in the cycle the result is shown, so records do not overlap.
// The receiver cannot stall: each result beat is valid for that single cycle.
// Reset empties the table (pages held and both totals to zero, no clearing
// pass is needed) and sets fast_limit to 64. fast_limit sits at byte address
// 0 of the APB port. The user must write it only while the block is idle;
// the block itself does not enforce this.
module first_touch_page_hit_counter_core
  import ftphc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned PAGE_BITS   = PAGE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Record channel.
  input  wire logic                  start,
  output logic                       busy,
  input  wire item_t                 item_i,
  // Result channel.
  output logic                       result_strobe_o,
  output result_t                    result_o,
  // Configuration port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  // Derived widths.
  localparam int unsigned KeyW  = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int unsigned IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned HeldW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CmpW  = (HeldW > LIMIT_W) ? HeldW : LIMIT_W;
  localparam logic [CmpW-1:0] DepthC = CmpW'(TABLE_DEPTH);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [HeldW-1:0]    held_q, held_d;
  logic                found_q, found_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [CREDIT_W-1:0] credit_q, credit_d;
  logic [TOTAL_W-1:0]  hit_sum_q, hit_sum_d;
  logic [TOTAL_W-1:0]  miss_sum_q, miss_sum_d;
  logic [LIMIT_W-1:0]  fast_limit_q;
  logic                strobe_q, strobe_d;
  result_t             result_q, result_d;

  logic                accept;
  logic                cfg_write;
  logic [IdxW-1:0]     rd_addr;
  logic [KeyW-1:0]     rd_data_q;
  logic                mem_we;
  logic [HeldW-1:0]    next_pos;
  logic                last_entry;
  logic [CmpW-1:0]     limit_ext;
  logic [CmpW-1:0]     limit_eff;
  logic                room;
  logic                hit;
  logic [TOTAL_W-1:0]  add_op;
  logic [TOTAL_W:0]    add_sum;
  logic [TOTAL_W-1:0]  add_sat;

  // Page table: one write port for appends, one registered read port for the search.
  logic [KeyW-1:0] page_table [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      page_table[held_q[IdxW-1:0]] <= key_q;
    end
    rd_data_q <= page_table[rd_addr];
  end

  // Configuration port: always ready, words decoded by address bit 2.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == REG_FAST_LIMIT);
  assign prdata    = (paddr[2] == REG_FAST_LIMIT)
                     ? {{(APB_DATA_W - LIMIT_W){1'b0}}, fast_limit_q}
                     : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_limit_q <= FAST_LIMIT_RESET;
    end else if (cfg_write) begin
      fast_limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // Handshake of the record channel.
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Search bookkeeping: the entry compared now and whether it is the last one held.
  assign next_pos   = HeldW'(idx_q) + HeldW'(1);
  assign last_entry = (next_pos == held_q);
  assign rd_addr    = accept ? '0 : IdxW'(next_pos);

  // Effective limit, clamped to the table depth, and whether a new page fits.
  assign limit_ext = CmpW'(fast_limit_q);
  assign limit_eff = (limit_ext > DepthC) ? DepthC : limit_ext;
  assign room      = (CmpW'(held_q) < limit_eff);
  assign hit       = found_q || room;
  assign mem_we    = (state_q == ST_DECIDE) && !found_q && room;

  // Shared saturating adder, steered to the hit or the miss total.
  assign add_op  = hit ? hit_sum_q : miss_sum_q;
  assign add_sum = {1'b0, add_op} + (TOTAL_W + 1)'(credit_q);
  assign add_sat = add_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : add_sum[TOTAL_W-1:0];

  // Sequencer: accept, walk the table one entry a cycle, then update and report.
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    held_d     = held_q;
    found_d    = found_q;
    key_d      = key_q;
    credit_d   = credit_q;
    hit_sum_d  = hit_sum_q;
    miss_sum_d = miss_sum_q;
    strobe_d   = 1'b0;
    result_d   = result_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d    = item_i.page_number[KeyW-1:0];
          credit_d = (item_i.access_count > COUNT_W'(CLIP_MAX))
                     ? CLIP_MAX : item_i.access_count[CREDIT_W-1:0];
          idx_d    = '0;
          found_d  = 1'b0;
          state_d  = (held_q == '0) ? ST_DECIDE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (rd_data_q == key_q) begin
          found_d = 1'b1;
          state_d = ST_DECIDE;
        end else if (last_entry) begin
          state_d = ST_DECIDE;
        end else begin
          idx_d = IdxW'(next_pos);
        end
      end
      ST_DECIDE: begin
        if (mem_we) begin
          held_d = held_q + HeldW'(1);
        end
        if (hit) begin
          hit_sum_d = add_sat;
        end else begin
          miss_sum_d = add_sat;
        end
        result_d.is_hit     = hit;
        result_d.new_page   = !found_q;
        result_d.credited   = credit_q;
        result_d.hit_total  = hit ? add_sat : hit_sum_q;
        result_d.miss_total = hit ? miss_sum_q : add_sat;
        strobe_d = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      held_q     <= '0;
      found_q    <= 1'b0;
      hit_sum_q  <= '0;
      miss_sum_q <= '0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      held_q     <= held_d;
      found_q    <= found_d;
      hit_sum_q  <= hit_sum_d;
      miss_sum_q <= miss_sum_d;
      strobe_q   <= strobe_d;
    end
  end

  // Payload registers of the record in flight and of the result beat.
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    credit_q <= credit_d;
    result_q <= result_d;
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = result_q;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for first_touch_page_hit_counter_core.
// Drives record beats and APB writes, predicts every result beat and compares.
// Depends on ftphc_pkg and the RTL of the core.
`default_nettype none

module tb_top
  import ftphc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 8;
  localparam int POOL_SIZE    = 96;
  localparam int PHASE_ITEMS  = 170;
  localparam int TAIL_CYCLES  = TABLE_DEPTH_DEF + 16;
  localparam int QUIET_LIMIT  = 4000;

  localparam logic [APB_ADDR_W-1:0] ADDR_LIMIT = APB_ADDR_W'(int'(REG_FAST_LIMIT) * 4);
  localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = APB_ADDR_W'((int'(REG_FAST_LIMIT) + 1) * 4);

  // Clock, reset and block inputs, all known from time zero.
  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  start   = 1'b0;
  item_t                 item_i  = '0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;

  logic                  busy;
  logic                  result_strobe_o;
  result_t               result_o;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  first_touch_page_hit_counter_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .item_i          (item_i),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Predictor state: a private copy of the page table, fill level, totals and limit.
  logic [PAGE_W-1:0]  page_table [TABLE_DEPTH_DEF];
  int unsigned        pages_held = 0;
  logic [TOTAL_W-1:0] hit_sum    = '0;
  logic [TOTAL_W-1:0] miss_sum   = '0;
  logic [LIMIT_W-1:0] limit_q    = FAST_LIMIT_RESET;

  // Record beats waiting to be driven and result beats waiting to arrive.
  item_t   pending_records [$];
  result_t predicted_results [$];

  int   records_queued   = 0;
  int   results_seen     = 0;
  int   errors           = 0;
  int   hits_seen        = 0;
  int   misses_seen      = 0;
  int   new_page_count   = 0;
  int   settings_written = 0;
  int   quiet_cycles     = 0;
  int   burst_left       = 1;
  int   gap_left         = 0;
  logic record_taken     = 1'b0;

  // Looks the page up, appends it while there is room and credits the clipped count.
  function automatic result_t place_record(item_t rec);
    result_t           res;
    int unsigned       cap;
    logic              found;
    logic [TOTAL_W:0]  sum;
    logic [CREDIT_W-1:0] credit;
    cap   = (limit_q > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : limit_q;
    found = 1'b0;
    for (int i = 0; i < pages_held; i++) begin
      if (page_table[i] == rec.page_number) found = 1'b1;
    end
    credit = (rec.access_count > CLIP_MAX) ? CLIP_MAX : rec.access_count[CREDIT_W-1:0];
    res.new_page = !found;
    if (found) begin
      res.is_hit = 1'b1;
    end else if (pages_held < cap) begin
      page_table[pages_held] = rec.page_number;
      pages_held++;
      res.is_hit = 1'b1;
    end else begin
      res.is_hit = 1'b0;
    end
    // Both totals saturate at the all-ones value.
    if (res.is_hit) begin
      sum     = {1'b0, hit_sum} + (TOTAL_W + 1)'(credit);
      hit_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    end else begin
      sum      = {1'b0, miss_sum} + (TOTAL_W + 1)'(credit);
      miss_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    end
    res.credited   = credit;
    res.hit_total  = hit_sum;
    res.miss_total = miss_sum;
    return res;
  endfunction

  task automatic check_result(input result_t want, input result_t got);
    if (got.is_hit !== want.is_hit) begin
      $display("%0t: is_hit expected %0d got %0d", $time, want.is_hit, got.is_hit);
      errors++;
    end
    if (got.new_page !== want.new_page) begin
      $display("%0t: new_page expected %0d got %0d", $time, want.new_page, got.new_page);
      errors++;
    end
    if (got.credited !== want.credited) begin
      $display("%0t: credited expected %0d got %0d", $time, want.credited, got.credited);
      errors++;
    end
    if (got.hit_total !== want.hit_total) begin
      $display("%0t: hit_total expected %0d got %0d", $time, want.hit_total, got.hit_total);
      errors++;
    end
    if (got.miss_total !== want.miss_total) begin
      $display("%0t: miss_total expected %0d got %0d", $time, want.miss_total, got.miss_total);
      errors++;
    end
  endtask

  // Driver: record beats go out at the falling edge in bursts separated by random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !record_taken) begin
      // The current beat has not been taken yet, so it is held.
    end else if (gap_left != 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (pending_records.size() != 0) begin
      start  <= 1'b1;
      item_i <= pending_records.pop_front();
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 40);
        case ($urandom_range(0, 3))
          0:       gap_left = 0;
          1:       gap_left = $urandom_range(20, 30);
          default: gap_left = $urandom_range(1, 8);
        endcase
      end else begin
        burst_left--;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: samples both channels at the rising edge and keeps the watchdog count.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      record_taken = 1'b0;
      quiet_cycles = 0;
    end else begin
      record_taken = start && !busy;
      if (result_strobe_o) begin
        results_seen++;
        if (result_o.is_hit) hits_seen++;
        else misses_seen++;
        if (result_o.new_page) new_page_count++;
        if (predicted_results.size() == 0) begin
          $display("%0t: result beat with none expected, actual %h", $time, result_o);
          errors++;
        end else begin
          check_result(predicted_results.pop_front(), result_o);
        end
      end
      if (record_taken) predicted_results = {predicted_results, place_record(item_i)};
      if (record_taken || result_strobe_o || (psel && penable && pready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  // One APB transfer: setup cycle, then access cycle until pready is seen.
  task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (wr && addr == ADDR_LIMIT) limit_q = data[LIMIT_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes a value with random upper bits, then reads fast_limit back.
  task automatic write_limit(input logic [APB_ADDR_W-1:0] addr, input int unsigned value);
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b1, addr, ($urandom() & ~32'h7F) | value, rd);
    settings_written++;
    apb_access(1'b0, ADDR_LIMIT, '0, rd);
    if (rd !== APB_DATA_W'(limit_q)) begin
      $display("%0t: fast_limit read expected %0d got %0d", $time, limit_q, rd);
      errors++;
    end
  endtask

  task automatic queue_record(input logic [PAGE_W-1:0] page, input logic [COUNT_W-1:0] count);
    item_t rec;
    rec.page_number  = page;
    rec.access_count = count;
    pending_records = {pending_records, rec};
    records_queued++;
  endtask

  // Waits until every queued record has produced its result beat.
  task automatic drain();
    do @(negedge clk_i); while (results_seen < records_queued);
  endtask

  initial begin
    logic [PAGE_W-1:0]     page_pool [POOL_SIZE];
    logic [63:0]           wide;
    logic [PAGE_W-1:0]     page;
    logic [COUNT_W-1:0]    count;
    logic [APB_DATA_W-1:0] rd;
    int unsigned           phase_limits [6];
    int unsigned           roll;

    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      wide = {$urandom(), $urandom()};
      page_pool[i] = wide[PAGE_W-1:0];
    end
    phase_limits = '{16, 8, 40, 0, 127, $urandom_range(0, 127)};

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The reset value of fast_limit must read back.
    apb_access(1'b0, ADDR_LIMIT, '0, rd);
    if (rd !== APB_DATA_W'(FAST_LIMIT_RESET)) begin
      $display("%0t: fast_limit after reset expected %0d got %0d", $time, FAST_LIMIT_RESET, rd);
      errors++;
    end

    // A zero limit on an empty table: every record misses.
    write_limit(ADDR_LIMIT, 0);
    queue_record('0, '0);
    queue_record('1, '1);
    queue_record('0, 16'd64);
    queue_record(52'h5, 16'd65);
    drain();

    // Two pages fit, then further new pages miss and stay unrecorded.
    write_limit(ADDR_LIMIT, 2);
    queue_record('0, 16'd1);
    queue_record('1, 16'd63);
    queue_record('0, 16'd64);
    queue_record(52'h7, '1);
    queue_record(52'h7, 16'd2);
    drain();

    // Lowering the limit keeps the held pages as hits.
    write_limit(ADDR_LIMIT, 1);
    queue_record('1, 16'd64);
    queue_record(52'h9, 16'd65);
    queue_record('0, 16'd3);
    drain();

    // A write beyond the register map leaves fast_limit alone.
    write_limit(ADDR_SPARE, 7'h7F);
    queue_record(52'h9, 16'd10);
    queue_record(52'hA_5A5A_5A5A_5A5A, 16'd64);
    drain();

    // A limit above the table depth acts as the full depth.
    write_limit(ADDR_LIMIT, 127);
    queue_record(52'h8_0000_0000_0000, '1);
    queue_record(52'h7_FFFF_FFFF_FFFF, 16'h8000);
    queue_record(52'h9, 16'd0);
    drain();

    // Random phases: mostly pages from a reused pool so that hits and full-table
    // misses both occur, with some fully random pages and counts.
    foreach (phase_limits[p]) begin
      write_limit(ADDR_LIMIT, phase_limits[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
          page = page_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          wide = {$urandom(), $urandom()};
          page = wide[PAGE_W-1:0];
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          count = COUNT_W'($urandom_range(0, 80));
        end else if (roll < 85) begin
          count = COUNT_W'($urandom());
        end else begin
          case ($urandom_range(0, 4))
            0:       count = '0;
            1:       count = 16'd63;
            2:       count = 16'd64;
            3:       count = 16'd65;
            default: count = '1;
          endcase
        end
        queue_record(page, count);
      end
      drain();
    end

    // Restore the reset setting and give any stray beat time to show.
    write_limit(ADDR_LIMIT, 64);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (predicted_results.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, predicted_results.size());
      errors++;
    end

    $display("Summary: %0d record beats checked across %0d limit register writes.",
             results_seen, settings_written);
    $display("Summary: %0d hits, %0d misses, %0d new pages, %0d table entries filled.",
             hits_seen, misses_seen, new_page_count, pages_held);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
